@@ rtl/core/i2c_master_write_waveform_macros.svh @@
// Assertion macros for the I2C write waveform generator.
// No dependencies; included by files that carry concurrent checks.
`ifndef I2C_MASTER_WRITE_WAVEFORM_MACROS_SVH
`define I2C_MASTER_WRITE_WAVEFORM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2CMW_CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMW_CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/i2cmw_pkg.sv @@
// Shared types and constants for the I2C write waveform generator.
// No dependencies.
package i2cmw_pkg;

   localparam int unsigned HOLD_W       = 10;
   localparam int unsigned BYTE_W       = 8;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd4;
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam logic [2:0] LAST_BIT      = 3'd7;
   localparam logic [1:0] LAST_PHASE    = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic              clock_level;
      logic              data_level;
      logic [HOLD_W-1:0] hold_us;
      logic              run_end;
   } rsp_payload_type;

   // Classified byte: what the sequencer has to emit for it.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              with_start;
      logic              with_stop;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

endpackage

@@ rtl/core/i2c_master_write_waveform.sv @@
// Write-only I2C master waveform generator: bytes in, SCL/SDA pin phases out.
// Depends on i2cmw_pkg, i2cmw_front, i2cmw_queue, i2cmw_back and the macros header.
// Usage:
//  - req_*: one transaction carries a data byte plus first/last flags. first_byte
//    prepends a start condition, last_byte appends a stop condition after the
//    acknowledge slot.
//  - rsp_*: one transaction per pin phase (SCL level, SDA level, hold time in us,
//    run_end on the final phase of a byte). A byte yields 27, 30 or 33 phases.
//  - csr_*: write of the phase hold interval; take effect on phases generated
//    after the write. Write only while the block is idle.
// Timing:
//  - an accepted request passes the front register, a queue entry and the
//    sequencer load before its first phase reaches the output register.
//  - throughput: one phase per cycle while rsp_ready is high, plus a load step
//    per byte in the phase sequencer before the byte's first phase.
//  - a front register and a two-entry queue take up to three bytes ahead while
//    the sequencer still works on an earlier one.
// Reset: clears queue, sequencer and output valid; hold interval returns to 4 us.
// Stall: with rsp_ready low the output register holds its phase and the
//   sequencer waits; the front keeps accepting until the queue is full and the front register holds a byte.
module i2c_master_write_waveform
   import i2cmw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_data,
   input  logic              csr_wr_en,
   input  logic [HOLD_W-1:0] csr_wr_data
);

`include "i2c_master_write_waveform_macros.svh"

   // hold interval register
   logic [HOLD_W-1:0] hold_ff, hold_in;

   logic             push;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type q_status;
   back_status_type  b_status;

   assign hold_in = csr_wr_en ? csr_wr_data : hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
      end else begin
         hold_ff <= hold_in;
      end
   end

   // front: accept and classify
   i2cmw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (q_status.full)
   );

   // decoupling queue
   i2cmw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (b_status.pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // back: phase sequencer and output register
   i2cmw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .hold_interval (hold_ff),
      .head_cmd      (head_cmd),
      .q_status      (q_status),
      .status        (b_status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

   // Checks
   `I2CMW_CHK_IMPL(chk_pop_nonempty, clock, reset,
      b_status.pop, !q_status.empty, "pop from empty queue")
   `I2CMW_CHK_IMPL(chk_busy_from_queue, clock, reset,
      $rose(b_status.busy), $past(!q_status.empty), "sequencer started without a queued byte")
   `I2CMW_CHK_NEXT(chk_push_lands, clock, reset,
      push, !q_status.empty, "pushed byte missing from queue")

endmodule

@@ rtl/core/i2cmw_front.sv @@
// Front end: input register and classification of incoming bytes.
// Depends on i2cmw_pkg.
module i2cmw_front
   import i2cmw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            push,
   output cmd_type         push_cmd,
   input  logic            queue_full
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign push      = valid_ff && !queue_full;
   assign req_ready = !valid_ff || !queue_full;
   assign take      = req_valid && req_ready;
   assign push_cmd  = cmd_ff;

   always_comb begin
      valid_in = take ? 1'b1 : (push ? 1'b0 : valid_ff);
      cmd_in   = cmd_ff;
      if (take) begin
         cmd_in.data_byte  = req_data.data_byte;
         cmd_in.with_start = req_data.first_byte;
         cmd_in.with_stop  = req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

@@ rtl/core/i2cmw_queue.sv @@
// Short command queue between front end and phase sequencer.
// Depends on i2cmw_pkg.
module i2cmw_queue
   import i2cmw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         bump = '0;
      end else begin
         bump = p + 1'b1;
      end
   endfunction

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/i2cmw_back.sv @@
// Back end: phase sequencer with registered result output.
// Depends on i2cmw_pkg.
module i2cmw_back
   import i2cmw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [HOLD_W-1:0] hold_interval,
   input  cmd_type           head_cmd,
   input  queue_status_type  q_status,
   output back_status_type   status,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_BITS,
      ST_ACK,
      ST_STOP
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        bit_ff, bit_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic              stop_ff, stop_in;
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_ff, out_in;

   logic can_load, pop;
   logic scl, sda, held, run_end;
   logic cur_bit;

   assign can_load  = !out_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign cur_bit   = shift_ff[BYTE_W-1];
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.pop  = pop;

   // Pin levels for the current phase.
   always_comb begin
      scl     = 1'b0;
      sda     = 1'b1;
      held    = 1'b1;
      run_end = 1'b0;
      case (state_ff)
         ST_START: begin
            scl = (phase_ff != LAST_PHASE);
            sda = (phase_ff == 2'd0);
         end
         ST_BITS: begin
            scl  = (phase_ff == 2'd1);
            sda  = cur_bit;
            held = (phase_ff != LAST_PHASE);
         end
         ST_ACK: begin
            scl     = (phase_ff == 2'd1);
            run_end = (phase_ff == LAST_PHASE) && !stop_ff;
         end
         ST_STOP: begin
            scl     = (phase_ff != 2'd0);
            sda     = (phase_ff == LAST_PHASE);
            held    = (phase_ff == 2'd1);
            run_end = (phase_ff == LAST_PHASE);
         end
         default: begin
            scl = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      stop_in      = stop_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;

      if (pop) begin
         // load step for each byte
         state_in = head_cmd.with_start ? ST_START : ST_BITS;
         phase_in = '0;
         bit_in   = '0;
         shift_in = head_cmd.data_byte;
         stop_in  = head_cmd.with_stop;
      end else if (state_ff != ST_IDLE && can_load) begin
         out_valid_in        = 1'b1;
         out_in.clock_level  = scl;
         out_in.data_level   = sda;
         out_in.hold_us      = held ? hold_interval : '0;
         out_in.run_end      = run_end;
         if (phase_ff != LAST_PHASE) begin
            phase_in = phase_ff + 1'b1;
         end else begin
            phase_in = '0;
            case (state_ff)
               ST_START: state_in = ST_BITS;
               ST_BITS: begin
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                  bit_in   = bit_ff + 1'b1;
                  if (bit_ff == LAST_BIT) begin
                     state_in = ST_ACK;
                  end
               end
               ST_ACK:  state_in = stop_ff ? ST_STOP : ST_IDLE;
               ST_STOP: state_in = ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      phase_ff <= phase_in;
      bit_ff   <= bit_in;
      shift_ff <= shift_in;
      stop_ff  <= stop_in;
      out_ff   <= out_in;
   end

endmodule

@@ tb/sv/i2c_master_write_waveform_checker.sv @@
`timescale 1ns / 1ps
// Checker for the I2C write waveform generator: expands each accepted byte into pin phases
// and compares them with the rsp channel. Depends on i2cmw_pkg.
module i2c_master_write_waveform_checker
   import i2cmw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_payload_type   req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_payload_type   rsp_data,
   input  logic              csr_wr_en,
   input  logic [HOLD_W-1:0] csr_wr_data,
   output logic [31:0]       mismatch_count,
   output logic [31:0]       phases_pending
);

   rsp_payload_type   expected_phases[$];
   logic [HOLD_W-1:0] hold_setting;
   int unsigned       phases_checked;

   initial begin
      mismatch_count = '0;
      phases_pending = '0;
      phases_checked = 0;
      hold_setting   = HOLD_RESET;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns  MISMATCH  %s", $time, msg);
      mismatch_count = mismatch_count + 1;
   endtask

   function automatic rsp_payload_type make_phase(input logic scl, input logic sda,
                                                  input logic held);
      rsp_payload_type ph;
      ph.clock_level = scl;
      ph.data_level  = sda;
      ph.hold_us     = held ? hold_setting : '0;
      ph.run_end     = 1'b0;
      return ph;
   endfunction

   // Start (optional), eight bits MSB first, ack slot, stop (optional).
   task automatic expand_byte_to_phases(input req_payload_type item);
      rsp_payload_type run [0:32];
      rsp_payload_type ph;
      int              n;
      int              b;
      int              i;
      n = 0;
      if (item.first_byte) begin
         run[n] = make_phase(1'b1, 1'b1, 1'b1); n++;
         run[n] = make_phase(1'b1, 1'b0, 1'b1); n++;
         run[n] = make_phase(1'b0, 1'b0, 1'b1); n++;
      end
      for (b = BYTE_W - 1; b >= 0; b--) begin
         run[n] = make_phase(1'b0, item.data_byte[b], 1'b1); n++;
         run[n] = make_phase(1'b1, item.data_byte[b], 1'b1); n++;
         run[n] = make_phase(1'b0, item.data_byte[b], 1'b0); n++;
      end
      // ack slot: SDA released, slave ack not sampled
      run[n] = make_phase(1'b0, 1'b1, 1'b1); n++;
      run[n] = make_phase(1'b1, 1'b1, 1'b1); n++;
      run[n] = make_phase(1'b0, 1'b1, 1'b1); n++;
      if (item.last_byte) begin
         run[n] = make_phase(1'b0, 1'b0, 1'b0); n++;
         run[n] = make_phase(1'b1, 1'b0, 1'b1); n++;
         run[n] = make_phase(1'b1, 1'b1, 1'b0); n++;
      end
      for (i = 0; i < n; i++) begin
         ph         = run[i];
         ph.run_end = (i == n - 1);
         expected_phases.push_back(ph);
      end
   endtask

   task automatic check_phase(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_phases.size() == 0) begin
         report_mismatch($sformatf("unexpected phase scl=%b sda=%b hold=%0d end=%b",
                                   got.clock_level, got.data_level, got.hold_us,
                                   got.run_end));
      end else begin
         want = expected_phases.pop_front();
         if (got.clock_level !== want.clock_level)
            report_mismatch($sformatf("phase %0d clock_level got %b want %b",
                                      phases_checked, got.clock_level, want.clock_level));
         if (got.data_level !== want.data_level)
            report_mismatch($sformatf("phase %0d data_level got %b want %b",
                                      phases_checked, got.data_level, want.data_level));
         if (got.hold_us !== want.hold_us)
            report_mismatch($sformatf("phase %0d hold_us got %0d want %0d",
                                      phases_checked, got.hold_us, want.hold_us));
         if (got.run_end !== want.run_end)
            report_mismatch($sformatf("phase %0d run_end got %b want %b",
                                      phases_checked, got.run_end, want.run_end));
      end
      phases_checked++;
   endtask

   // Compare before expanding so a phase can never match a byte taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         hold_setting = HOLD_RESET;
         expected_phases.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_phase(rsp_data);
         if (csr_wr_en) hold_setting = csr_wr_data;
         if (req_valid && req_ready) expand_byte_to_phases(req_data);
      end
      phases_pending <= expected_phases.size();
   end

endmodule

@@ tb/sv/tb_i2c_master_write_waveform.sv @@
`timescale 1ns / 1ps
// Top of the I2C write waveform generator testbench: clock, reset, stimulus and verdict.
// Depends on i2cmw_pkg, the generator RTL and i2c_master_write_waveform_checker.
module tb_i2c_master_write_waveform;
   import i2cmw_pkg::*;

   // Settle time before a register write and at the end.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Slowest legal run: ~475 bytes x 33 phases, each behind the longest random
   // stall, plus hold-offs, taken several times over.
   localparam int unsigned CYCLE_LIMIT = 3000000;
   // Length of the long receiver hold-off that fills the input queue.
   localparam int unsigned SQUEEZE_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES = 5;
   localparam int unsigned ITEMS_PER_PHASE = 90;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_payload_type   req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_payload_type   rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [HOLD_W-1:0] csr_wr_data = '0;

   logic [31:0]       mismatch_count;
   logic [31:0]       phases_pending;

   int unsigned cycle_count = 0;
   int unsigned req_quiet_left = 0;
   int unsigned rsp_gap_left = 0;
   int unsigned rsp_quiet_left = 0;
   int unsigned hold_off_left = 0;
   // Stimulus bumps squeeze_asked; the receiver process answers each bump once.
   int unsigned squeeze_asked = 0;
   int unsigned squeeze_done = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   i2c_master_write_waveform DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   i2c_master_write_waveform_checker phase_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .phases_pending (phases_pending)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random stalls, quiet stretches with rsp_ready held high,
   // and on request one long hold-off so the front and queue fill and
   // req_ready drops while the sender keeps offering.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_ready     <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (squeeze_done != squeeze_asked) begin
         rsp_ready     <= 1'b0;
         hold_off_left <= SQUEEZE_CYCLES;
         squeeze_done  <= squeeze_asked;
      end else if (rsp_gap_left != 0) begin
         rsp_ready    <= 1'b0;
         rsp_gap_left <= rsp_gap_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_quiet_left != 0) begin
            rsp_quiet_left <= rsp_quiet_left - 1;
         end else if ($urandom_range(0, 99) == 0) begin
            rsp_quiet_left <= $urandom_range(30, 200);
         end else begin
            rsp_gap_left <= pick_gap();
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("i2c_master_write_waveform verification failed");
         $finish;
      end
   end

   // Offer one byte and hold it until the transaction completes, then maybe idle.
   // Entered and left at a rising-edge time step.
   task automatic offer_byte(input logic [BYTE_W-1:0] value, input logic first,
                             input logic last);
      req_payload_type item;
      int unsigned     gap;
      item.data_byte  = value;
      item.first_byte = first;
      item.last_byte  = last;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      if (req_quiet_left != 0) begin
         req_quiet_left--;
      end else if ($urandom_range(0, 49) == 0) begin
         req_quiet_left = $urandom_range(20, 60);
      end else begin
         gap = pick_gap();
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid (no duplicate transaction), wait until every phase is in,
   // then let the sequencer settle. Pending count is read at the falling edge.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (phases_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hold(input logic [HOLD_W-1:0] value);
      wait_idle();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed transfers (start on the first byte, stop on the last),
   // the rest single bytes with random flags.
   task automatic send_random_items(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      int unsigned k;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
               offer_byte(BYTE_W'($urandom_range(0, 255)), k == 0, k == len - 1);
            end
            sent += len;
         end else begin
            offer_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      int unsigned p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset hold interval: all flag combinations, all-zero / all-one bytes,
      // single set bit at each end, both flags together (33 phases).
      offer_byte(8'h00, 1'b0, 1'b0);
      offer_byte(8'hFF, 1'b0, 1'b0);
      offer_byte(8'hA5, 1'b1, 1'b0);
      offer_byte(8'h5A, 1'b0, 1'b1);
      offer_byte(8'h80, 1'b1, 1'b1);
      offer_byte(8'h01, 1'b1, 1'b1);

      // Long receiver hold-off while bytes keep coming: input must back up.
      squeeze_asked <= squeeze_asked + 1;
      offer_byte(8'h3C, 1'b1, 1'b0);
      offer_byte(8'hC3, 1'b0, 1'b0);
      offer_byte(8'h0F, 1'b0, 1'b0);
      offer_byte(8'hF0, 1'b0, 1'b1);
      offer_byte(8'h96, 1'b1, 1'b1);
      offer_byte(8'h69, 1'b0, 1'b0);

      // Zero hold interval: held phases report 0 too.
      write_hold('0);
      offer_byte(8'hFF, 1'b1, 1'b1);
      offer_byte(8'h00, 1'b0, 1'b0);
      offer_byte(8'h55, 1'b1, 1'b0);

      // Largest hold interval.
      write_hold({HOLD_W{1'b1}});
      offer_byte(8'hAA, 1'b0, 1'b1);
      offer_byte(8'hFF, 1'b1, 1'b1);
      offer_byte(8'h00, 1'b1, 1'b1);

      // Random phases, each under its own hold interval; second hold-off midway.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) write_hold(10'd1);
         else write_hold(HOLD_W'($urandom_range(0, 1023)));
         if (p == 2) squeeze_asked <= squeeze_asked + 1;
         send_random_items(ITEMS_PER_PHASE);
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("i2c_master_write_waveform verification clean");
      end else begin
         $display("i2c_master_write_waveform verification failed");
      end
      $finish;
   end

endmodule
